>>> sv/efu_pkg.sv
// Shared types and constants for the task event flag unit.
`timescale 1ns / 1ps
`default_nettype none

package efu_pkg;

   localparam int ID_W   = 4;
   localparam int MASK_W = 32;
   localparam int CMD_W  = 3;
   localparam int STAT_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_DECLARE = 3'd0,
      CMD_SET     = 3'd1,
      CMD_CLEAR   = 3'd2,
      CMD_GET     = 3'd3,
      CMD_WAIT    = 3'd4
   } efu_cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_ID    = 3'd1,
      ST_BAD_STATE = 3'd2,
      ST_RESOURCE  = 3'd3,
      ST_NO_FREE   = 3'd4
   } efu_status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } efu_state_type;

   typedef struct packed {
      efu_status_type     status;
      logic [MASK_W-1:0]  event_mask;
      logic               wake_target;
      logic               block_current;
   } efu_res_type;

endpackage

`default_nettype wire

>>> sv/efu_if.sv
// Request and response channel interfaces of the task event flag unit.
`timescale 1ns / 1ps
`default_nettype none

interface efu_req_if;
   logic                        valid;
   logic                        ready;
   logic [efu_pkg::CMD_W-1:0]   cmd;
   logic [efu_pkg::ID_W-1:0]    task_id;
   logic [efu_pkg::ID_W-1:0]    current_task;
   logic [efu_pkg::MASK_W-1:0]  mask;
   logic                        task_present;
   logic                        target_suspended;
   logic                        resource_held;

   modport source (output valid, cmd, task_id, current_task, mask, task_present,
                   target_suspended, resource_held, input ready);
   modport sink   (input valid, cmd, task_id, current_task, mask, task_present,
                   target_suspended, resource_held, output ready);
endinterface

interface efu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [efu_pkg::STAT_W-1:0]  status;
   logic [efu_pkg::MASK_W-1:0]  event_mask;
   logic                        wake_target;
   logic                        block_current;

   modport source (output valid, status, event_mask, wake_target, block_current,
                   input ready);
   modport sink   (input valid, status, event_mask, wake_target, block_current,
                   output ready);
endinterface

`default_nettype wire

>>> sv/efu_table.sv
// Per-task flag memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module efu_table #(
   parameter int TASK_COUNT = 16,
   parameter int ENTRY_W    = 96,
   parameter int ADDR_W     = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output logic      [ENTRY_W-1:0] rd_data,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire logic [ENTRY_W-1:0] wr_data
);

   logic [ENTRY_W-1:0]    mem [TASK_COUNT];
   logic [TASK_COUNT-1:0] valid_ff;
   logic [TASK_COUNT-1:0] valid_in;
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic                  rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // never-written entries read as all zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

>>> sv/efu_alu.sv
// Command evaluation: checks one request against its task entry, forms the update.
`timescale 1ns / 1ps
`default_nettype none

module efu_alu #(
   parameter int EVENT_BITS = 32
) (
   input  wire logic [efu_pkg::CMD_W-1:0]  cmd,
   input  wire logic                       id_ok,
   input  wire logic [efu_pkg::MASK_W-1:0] mask,
   input  wire logic                       task_present,
   input  wire logic                       target_suspended,
   input  wire logic                       resource_held,
   input  wire logic [3*EVENT_BITS-1:0]    entry_rd,
   output logic      [3*EVENT_BITS-1:0]    entry_wr,
   output logic                            wr_en,
   output efu_pkg::efu_res_type            res
);

   logic [EVENT_BITS-1:0]      decl, trig, wait_m;
   logic [EVENT_BITS-1:0]      decl_n, trig_n, wait_n;
   logic [EVENT_BITS-1:0]      free_b, lowest, m_ev;
   logic [efu_pkg::MASK_W-1:0] decl32;

   assign decl   = entry_rd[3*EVENT_BITS-1:2*EVENT_BITS];
   assign trig   = entry_rd[2*EVENT_BITS-1:EVENT_BITS];
   assign wait_m = entry_rd[EVENT_BITS-1:0];
   assign m_ev   = mask[EVENT_BITS-1:0];
   assign decl32 = efu_pkg::MASK_W'(decl);
   assign free_b = ~decl;
   // isolate the lowest free bit
   assign lowest = free_b & (~free_b + EVENT_BITS'(1));
   assign entry_wr = {decl_n, trig_n, wait_n};

   always_comb begin
      res.status        = efu_pkg::ST_OK;
      res.event_mask    = '0;
      res.wake_target   = 1'b0;
      res.block_current = 1'b0;
      wr_en  = 1'b0;
      decl_n = decl;
      trig_n = trig;
      wait_n = wait_m;
      case (cmd)
         efu_pkg::CMD_DECLARE: begin
            if (!id_ok) begin
               res.status = efu_pkg::ST_BAD_ID;
            end else if (free_b == '0) begin
               res.status = efu_pkg::ST_NO_FREE;
            end else begin
               res.event_mask = efu_pkg::MASK_W'(lowest);
               decl_n = decl | lowest;
               wr_en  = 1'b1;
            end
         end
         efu_pkg::CMD_SET: begin
            if (!id_ok || !task_present) begin
               res.status = efu_pkg::ST_BAD_ID;
            end else if ((decl32 & mask) != mask) begin
               res.status = efu_pkg::ST_BAD_ID;
            end else if (target_suspended) begin
               res.status = efu_pkg::ST_BAD_STATE;
            end else begin
               trig_n = trig | m_ev;
               wr_en  = 1'b1;
               res.wake_target = (wait_m & m_ev) != '0;
            end
         end
         efu_pkg::CMD_CLEAR: begin
            if (!id_ok) begin
               res.status = efu_pkg::ST_BAD_ID;
            end else begin
               trig_n = trig & ~m_ev;
               wait_n = wait_m & ~m_ev;
               wr_en  = 1'b1;
            end
         end
         efu_pkg::CMD_GET: begin
            if (!id_ok || !task_present) begin
               res.status = efu_pkg::ST_BAD_ID;
            end else if (target_suspended) begin
               res.status = efu_pkg::ST_BAD_STATE;
            end else begin
               res.event_mask = efu_pkg::MASK_W'(trig & wait_m);
            end
         end
         efu_pkg::CMD_WAIT: begin
            if (!id_ok) begin
               res.status = efu_pkg::ST_BAD_ID;
            end else if (resource_held) begin
               res.status = efu_pkg::ST_RESOURCE;
            end else begin
               wait_n = m_ev;
               wr_en  = 1'b1;
               res.block_current = (m_ev != '0) && ((trig & m_ev) == '0);
            end
         end
         default: begin
            res.status = efu_pkg::ST_BAD_ID;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> sv/task_event_flag_unit.sv
// Top level of the task event flag unit: sequencer, request capture, result register.
//
//   port     dir   transfer holds
//   req_ch   in    cmd, task ids, event mask, task state flags
//   rsp_ch   out   status, event mask, wake and block indications
//
// The task entry is read from the flag memory in the accept cycle and is
// modified and written back when the execute step loads the result register.
// The next request is taken in the cycle after write-back, so a read always
// sees the previous update. Reset clears the per-entry valid bits at once.
// A stalled response holds its register; a finished request waits in the
// execute step only while an earlier response is still not taken.
`timescale 1ns / 1ps
`default_nettype none

module task_event_flag_unit #(
   parameter int TASK_COUNT = 16,
   parameter int EVENT_BITS = 32
) (
   input wire logic clock,
   input wire logic reset,
   efu_req_if.sink   req_ch,
   efu_rsp_if.source rsp_ch
);

   localparam int ADDR_W  = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int ENTRY_W = 3 * EVENT_BITS;

   efu_pkg::efu_state_type state_ff, state_in;

   logic [efu_pkg::CMD_W-1:0]  cmd_ff;
   logic [efu_pkg::MASK_W-1:0] mask_ff;
   logic                       present_ff, susp_ff, res_held_ff, id_ok_ff;
   logic [ADDR_W-1:0]          addr_ff;

   logic                          accept, load;
   logic [efu_pkg::ID_W-1:0]      sel_id;
   logic [ADDR_W+efu_pkg::ID_W-1:0] sel_ext;
   logic [ADDR_W-1:0]             sel_addr;
   logic                          sel_ok;

   logic [ENTRY_W-1:0]   entry_rd, entry_wr;
   logic                 alu_wr;
   efu_pkg::efu_res_type alu_res;

   logic                 out_valid_ff, out_valid_in;
   efu_pkg::efu_res_type out_ff;

   assign accept = req_ch.valid && req_ch.ready;

   // clear and wait act on the running task, the rest on the target
   always_comb begin
      case (req_ch.cmd)
         efu_pkg::CMD_CLEAR, efu_pkg::CMD_WAIT: sel_id = req_ch.current_task;
         default:                               sel_id = req_ch.task_id;
      endcase
   end

   assign sel_ext  = {{ADDR_W{1'b0}}, sel_id};
   assign sel_addr = sel_ext[ADDR_W-1:0];
   assign sel_ok   = 32'(sel_id) < 32'(TASK_COUNT);

   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      load         = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      case (state_ff)
         efu_pkg::S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = efu_pkg::S_EXEC;
            end
         end
         efu_pkg::S_EXEC: begin
            // hold until the result register frees up
            if (!out_valid_ff || rsp_ch.ready) begin
               load         = 1'b1;
               out_valid_in = 1'b1;
               state_in     = efu_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = efu_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= efu_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_ch.cmd;
         mask_ff     <= req_ch.mask;
         present_ff  <= req_ch.task_present;
         susp_ff     <= req_ch.target_suspended;
         res_held_ff <= req_ch.resource_held;
         id_ok_ff    <= sel_ok;
         addr_ff     <= sel_addr;
      end
      if (load) begin
         out_ff <= alu_res;
      end
   end

   efu_table #(
      .TASK_COUNT (TASK_COUNT),
      .ENTRY_W    (ENTRY_W),
      .ADDR_W     (ADDR_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (sel_addr),
      .rd_data (entry_rd),
      .wr_en   (load && alu_wr),
      .wr_addr (addr_ff),
      .wr_data (entry_wr)
   );

   efu_alu #(
      .EVENT_BITS (EVENT_BITS)
   ) u_alu (
      .cmd              (cmd_ff),
      .id_ok            (id_ok_ff),
      .mask             (mask_ff),
      .task_present     (present_ff),
      .target_suspended (susp_ff),
      .resource_held    (res_held_ff),
      .entry_rd         (entry_rd),
      .entry_wr         (entry_wr),
      .wr_en            (alu_wr),
      .res              (alu_res)
   );

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.status        = out_ff.status;
   assign rsp_ch.event_mask    = out_ff.event_mask;
   assign rsp_ch.wake_target   = out_ff.wake_target;
   assign rsp_ch.block_current = out_ff.block_current;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == efu_pkg::S_EXEC)
      else $error("accepted request did not enter execute");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == efu_pkg::S_EXEC))
      else $error("response appeared without an executed request");

   a_wake_block_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.wake_target && out_ff.block_current))
      else $error("wake and block reported together");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status != efu_pkg::ST_OK) |->
         (out_ff.event_mask == '0 && !out_ff.wake_target && !out_ff.block_current))
      else $error("error response carries event data");

endmodule

`default_nettype wire

>>> tb/sv/task_event_flag_unit_tb.sv
// Self-checking testbench for the task event flag unit: directed and random service calls.
`timescale 1ns / 1ps

typedef struct {
   logic [efu_pkg::CMD_W-1:0]  cmd;
   logic [efu_pkg::ID_W-1:0]   task_id;
   logic [efu_pkg::ID_W-1:0]   current_task;
   logic [efu_pkg::MASK_W-1:0] mask;
   logic                       task_present;
   logic                       target_suspended;
   logic                       resource_held;
} svc_call_type;

class flag_table_board;
   localparam int TASKS = 16;

   bit [efu_pkg::MASK_W-1:0] declared_ev[TASKS];
   bit [efu_pkg::MASK_W-1:0] triggered_ev[TASKS];
   bit [efu_pkg::MASK_W-1:0] waited_ev[TASKS];
   efu_pkg::efu_res_type     due_replies[$];
   int errors;
   int replies;
   int wakes;
   int blocks;
   int no_free;

   task report(string what);
      $display("ERROR @%0t: %s", $realtime, what);
      errors++;
   endtask

   // Apply one service call to the shadow table and return the reply it must produce.
   function efu_pkg::efu_res_type serve_call(svc_call_type c);
      efu_pkg::efu_res_type r;
      bit [efu_pkg::MASK_W-1:0] free_bits;
      r.status        = efu_pkg::ST_OK;
      r.event_mask    = '0;
      r.wake_target   = 1'b0;
      r.block_current = 1'b0;
      case (c.cmd)
         efu_pkg::CMD_DECLARE: begin
            free_bits = ~declared_ev[c.task_id];
            if (free_bits == '0) begin
               r.status = efu_pkg::ST_NO_FREE;
            end else begin
               r.event_mask = free_bits & (-free_bits);
               declared_ev[c.task_id] |= r.event_mask;
            end
         end
         efu_pkg::CMD_SET: begin
            if (!c.task_present || ((declared_ev[c.task_id] & c.mask) != c.mask)) begin
               r.status = efu_pkg::ST_BAD_ID;
            end else if (c.target_suspended) begin
               r.status = efu_pkg::ST_BAD_STATE;
            end else begin
               triggered_ev[c.task_id] |= c.mask;
               r.wake_target = (waited_ev[c.task_id] & c.mask) != '0;
            end
         end
         efu_pkg::CMD_CLEAR: begin
            triggered_ev[c.current_task] &= ~c.mask;
            waited_ev[c.current_task]    &= ~c.mask;
         end
         efu_pkg::CMD_GET: begin
            if (!c.task_present) begin
               r.status = efu_pkg::ST_BAD_ID;
            end else if (c.target_suspended) begin
               r.status = efu_pkg::ST_BAD_STATE;
            end else begin
               r.event_mask = triggered_ev[c.task_id] & waited_ev[c.task_id];
            end
         end
         efu_pkg::CMD_WAIT: begin
            if (c.resource_held) begin
               r.status = efu_pkg::ST_RESOURCE;
            end else begin
               waited_ev[c.current_task] = c.mask;
               r.block_current = (c.mask != '0) &&
                                 ((triggered_ev[c.current_task] & c.mask) == '0);
            end
         end
         default: begin
            r.status = efu_pkg::ST_BAD_ID;
         end
      endcase
      return r;
   endfunction

   function void note_call(svc_call_type c);
      due_replies.push_back(serve_call(c));
   endfunction

   task check_reply(logic [efu_pkg::STAT_W-1:0] status, logic [efu_pkg::MASK_W-1:0] ev,
                    logic wake, logic blk);
      efu_pkg::efu_res_type exp_r;
      if (due_replies.size() == 0) begin
         report($sformatf("unexpected reply status=%0d mask=%h", status, ev));
      end else begin
         exp_r = due_replies.pop_front();
         replies++;
         if (status !== exp_r.status)
            report($sformatf("status %0d, want %0d", status, exp_r.status));
         if (ev !== exp_r.event_mask)
            report($sformatf("event_mask %h, want %h", ev, exp_r.event_mask));
         if (wake !== exp_r.wake_target)
            report($sformatf("wake_target %b, want %b", wake, exp_r.wake_target));
         if (blk !== exp_r.block_current)
            report($sformatf("block_current %b, want %b", blk, exp_r.block_current));
         if (exp_r.wake_target) wakes++;
         if (exp_r.block_current) blocks++;
         if (exp_r.status == efu_pkg::ST_NO_FREE) no_free++;
      end
   endtask
endclass

module task_event_flag_unit_tb;

   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_CALLS = 690;

   logic clock = 1'b0;
   logic reset;
   logic steady = 1'b0;
   int   quiet_cycles = 0;
   int   calls_sent = 0;

   flag_table_board board = new();

   efu_req_if req_ch();
   efu_rsp_if rsp_ch();

   task_event_flag_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #6 clock = ~clock;

   // Check replies and throttle the response side.
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready)
         board.check_reply(rsp_ch.status, rsp_ch.event_mask, rsp_ch.wake_target,
                           rsp_ch.block_current);
      rsp_ch.ready <= !reset && (steady || ($urandom_range(99) >= 12));
   end

   // Watchdog: count cycles without any transfer.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("task_event_flag_unit: mismatch");
         $finish;
      end
   end

   task automatic push_call(input svc_call_type c);
      while (!steady && $urandom_range(99) < 12) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.cmd              <= c.cmd;
      req_ch.task_id          <= c.task_id;
      req_ch.current_task     <= c.current_task;
      req_ch.mask             <= c.mask;
      req_ch.task_present     <= c.task_present;
      req_ch.target_suspended <= c.target_suspended;
      req_ch.resource_held    <= c.resource_held;
      do @(posedge clock); while (!req_ch.ready);
      board.note_call(c);
      calls_sent++;
   endtask

   task automatic call(input logic [efu_pkg::CMD_W-1:0] cmd, input int tid, input int cur,
                       input logic [efu_pkg::MASK_W-1:0] m, input int present,
                       input int susp, input int res);
      svc_call_type c;
      c.cmd              = cmd;
      c.task_id          = tid[efu_pkg::ID_W-1:0];
      c.current_task     = cur[efu_pkg::ID_W-1:0];
      c.mask             = m;
      c.task_present     = present[0];
      c.target_suspended = susp[0];
      c.resource_held    = res[0];
      push_call(c);
   endtask

   // Hold the request side until every reply is in.
   task automatic drain;
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.due_replies.size() != 0);
   endtask

   function automatic svc_call_type random_call();
      svc_call_type c;
      int pick;
      pick = $urandom_range(99);
      c.task_id          = ($urandom_range(99) < 70) ?
                           efu_pkg::ID_W'($urandom_range(0, 3)) :
                           efu_pkg::ID_W'($urandom_range(0, 15));
      c.current_task     = ($urandom_range(99) < 70) ?
                           efu_pkg::ID_W'($urandom_range(0, 3)) :
                           efu_pkg::ID_W'($urandom_range(0, 15));
      c.task_present     = $urandom_range(99) < 90;
      c.target_suspended = $urandom_range(99) < 10;
      c.resource_held    = $urandom_range(99) < 10;
      c.mask             = $urandom();
      if (pick < 15) begin
         c.cmd = efu_pkg::CMD_DECLARE;
         c.task_present = 1'($urandom_range(1));
      end else if (pick < 45) begin
         c.cmd = efu_pkg::CMD_SET;
         // mostly declared bits so sets get through
         if ($urandom_range(99) < 85)
            c.mask = board.declared_ev[c.task_id] & $urandom();
      end else if (pick < 55) begin
         c.cmd = efu_pkg::CMD_CLEAR;
         if ($urandom_range(1)) c.mask = $urandom() & $urandom();
      end else if (pick < 75) begin
         c.cmd = efu_pkg::CMD_GET;
      end else if (pick < 96) begin
         c.cmd = efu_pkg::CMD_WAIT;
         if ($urandom_range(99) < 75)
            c.mask = board.declared_ev[c.current_task] & $urandom();
      end else begin
         c.cmd = efu_pkg::CMD_W'($urandom_range(5, 7));
      end
      return c;
   endfunction

   initial begin
      req_ch.valid            <= 1'b0;
      req_ch.cmd              <= efu_pkg::CMD_DECLARE;
      req_ch.task_id          <= '0;
      req_ch.current_task     <= '0;
      req_ch.mask             <= '0;
      req_ch.task_present     <= 1'b0;
      req_ch.target_suspended <= 1'b0;
      req_ch.resource_held    <= 1'b0;
      reset                   <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed calls
      call(efu_pkg::CMD_GET,     0,  0, '0,            1, 0, 0);
      call(efu_pkg::CMD_DECLARE, 3,  0, '0,            1, 0, 0);
      call(efu_pkg::CMD_DECLARE, 3,  0, '0,            1, 0, 0);
      call(efu_pkg::CMD_DECLARE, 7,  0, '0,            0, 0, 0);  // absent task still allocates
      call(efu_pkg::CMD_WAIT,    0,  3, 32'h3,         1, 0, 0);
      call(efu_pkg::CMD_SET,     3,  0, 32'h1,         1, 0, 0);
      call(efu_pkg::CMD_GET,     3,  0, '0,            1, 0, 0);
      call(efu_pkg::CMD_GET,     3,  0, '0,            1, 1, 0);
      call(efu_pkg::CMD_GET,     3,  0, '0,            0, 0, 0);
      call(efu_pkg::CMD_SET,     3,  0, '0,            1, 0, 0);  // empty mask
      call(efu_pkg::CMD_SET,     3,  0, 32'h4,         1, 0, 0);  // undeclared bit
      call(efu_pkg::CMD_SET,     3,  0, 32'h8000_0000, 1, 0, 0);
      call(efu_pkg::CMD_SET,     3,  0, 32'h2,         1, 1, 0);
      call(efu_pkg::CMD_SET,     3,  0, 32'h2,         0, 0, 0);
      call(efu_pkg::CMD_WAIT,    0,  3, 32'h2,         1, 0, 1);
      call(efu_pkg::CMD_WAIT,    0,  3, 32'hFFFF_FFFF, 1, 0, 0);  // already triggered
      call(efu_pkg::CMD_CLEAR,   0,  3, 32'hFFFF_FFFF, 1, 0, 0);
      call(efu_pkg::CMD_WAIT,    0,  3, '0,            1, 0, 0);
      call(efu_pkg::CMD_DECLARE, 15, 0, '0,            1, 0, 0);
      call(efu_pkg::CMD_WAIT,    0, 15, 32'h1,         1, 0, 0);
      call(efu_pkg::CMD_SET,     15, 0, 32'h1,         1, 0, 0);
      call(efu_pkg::CMD_GET,     15, 0, '0,            1, 0, 0);
      call(3'd5,                 1,  1, '1,            1, 0, 0);
      call(3'd6,                 2,  2, '0,            1, 1, 1);
      call(3'd7,                 15, 15, '1,           0, 1, 1);
      drain();

      // exhaust the event bits of one task, two past full
      for (int i = 0; i < 34; i++)
         call(efu_pkg::CMD_DECLARE, 14, 0, $urandom(), $urandom_range(1), 0, 0);

      for (int i = 0; i < RANDOM_CALLS; i++) begin
         steady = (i >= 300) && (i < 420);
         if (i == RANDOM_CALLS / 2) drain();
         push_call(random_call());
      end
      steady = 1'b0;
      drain();
      repeat (10) @(posedge clock);

      $display("coverage: %0d service calls, %0d replies checked", calls_sent, board.replies);
      $display("coverage: %0d wakes, %0d blocks, %0d no-free-event refusals",
               board.wakes, board.blocks, board.no_free);
      if (board.errors == 0 && board.due_replies.size() == 0)
         $display("task_event_flag_unit: match");
      else
         $display("task_event_flag_unit: mismatch");
      $finish;
   end
endmodule

>>> task_event_flag_unit.f
sv/efu_pkg.sv
sv/efu_if.sv
sv/efu_table.sv
sv/efu_alu.sv
sv/task_event_flag_unit.sv
tb/sv/task_event_flag_unit_tb.sv
